// File: rtl/bsd_pkg.sv
// bsd_pkg: widths, types and defaults for the bounded squared distance block
// no dependencies; used by the channel interfaces, the top level and the checker
`default_nettype none

package bsd_pkg;

   localparam int ELEM_W       = 16;
   localparam int DIST_W       = 48;
   localparam int MAG_W        = 16;
   localparam int SQ_W         = 2 * MAG_W;
   localparam int DIMS_DEFAULT = 16;
   localparam int DIMS_MAX     = 256;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [DIST_W-1:0]        dist_type;
   typedef logic [SQ_W-1:0]          sq_type;

   // position of an item within its vector
   typedef struct packed {
      logic first;
      logic last;
      logic check;
   } pos_type;

endpackage

`default_nettype wire

// File: rtl/bsd_req_if.sv
// bsd_req_if: valid/ready channel carrying one dimension item of two vectors
// depends on bsd_pkg
`default_nettype none

interface bsd_req_if;
   import bsd_pkg::*;

   logic     valid;
   logic     ready;
   elem_type elem_own;
   elem_type elem_other;
   logic     bound_enable;
   dist_type bound_limit;

   modport source (output valid, elem_own, elem_other, bound_enable, bound_limit,
                   input ready);
   modport sink   (input valid, elem_own, elem_other, bound_enable, bound_limit,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/bsd_rsp_if.sv
// bsd_rsp_if: valid/ready channel carrying one distance result item
// depends on bsd_pkg
`default_nettype none

interface bsd_rsp_if;
   import bsd_pkg::*;

   logic     valid;
   logic     ready;
   dist_type distance;
   logic     stopped_early;

   modport source (output valid, distance, stopped_early, input ready);
   modport sink   (input valid, distance, stopped_early, output ready);
endinterface

`default_nettype wire

// File: rtl/bounded_squared_distance.sv
// bounded_squared_distance: streamed squared euclidean distance with early exit
// depends on bsd_pkg, bsd_req_if and bsd_rsp_if
//
// One item per cycle is taken on req_chan, each holding one dimension of both
// vectors; DIMS items form one vector. The item passes an input register, a
// stage that squares the element difference and a stage that accumulates and
// compares against the bound and writes the result register that drives
// rsp_chan; items keep flowing at one per cycle as long as rsp_chan takes
// results. Bound and enable are read from the first item of a vector; with the
// bound enabled, a stop is reported as soon as the sum exceeds it at a checked
// dimension, and the rest of that vector yields nothing.
`default_nettype none

module bounded_squared_distance #(
   parameter int DIMS = bsd_pkg::DIMS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   bsd_req_if.sink          req_chan,
   bsd_rsp_if.source        rsp_chan
);
   import bsd_pkg::*;

   localparam int IDX_W         = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int FIRST_CHECKED = (2 * DIMS) / 5;

   // dimension counter
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W+1:0] idx_ext;
   pos_type          pos;

   // stage 1: input register
   logic     s1_valid_ff, s1_valid_in;
   elem_type s1_own_ff, s1_other_ff;
   pos_type  s1_pos_ff;
   logic     s1_enable_ff;
   dist_type s1_bound_ff;

   // stage 2: squared difference
   logic     s2_valid_ff, s2_valid_in;
   sq_type   s2_sq_ff;
   pos_type  s2_pos_ff;
   logic     s2_enable_ff;
   dist_type s2_bound_ff;

   // accumulator state
   dist_type sum_ff, sum_in;
   logic     halted_ff, halted_in;
   dist_type bound_ff, bound_in;
   logic     mode_ff, mode_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   dist_type rsp_dist_ff, rsp_dist_in;
   logic     rsp_stop_ff, rsp_stop_in;

   logic accept, adv1, adv2, s2_free, out_free;
   logic signed [ELEM_W:0] diff;
   logic [ELEM_W:0]        diff_abs;
   logic [MAG_W-1:0]       mag;
   sq_type                 sq;

   dist_type base, acc, bnd;
   logic     halt_eff, mode_eff, stop, produce;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign adv2     = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || adv2;
   assign adv1     = s1_valid_ff && s2_free;
   assign req_chan.ready = !s1_valid_ff || adv1;
   assign accept   = req_chan.valid && req_chan.ready;

   always_comb begin
      idx_ext   = {2'b00, idx_ff};
      pos.first = (idx_ff == '0);
      pos.last  = (idx_ff == IDX_W'(DIMS - 1));
      pos.check = (idx_ext >= (IDX_W+2)'(FIRST_CHECKED)) && (idx_ext[1:0] == 2'b00);
      idx_in    = idx_ff;
      if (accept) begin
         idx_in = pos.last ? '0 : idx_ff + 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (adv1) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      diff     = {s1_own_ff[ELEM_W-1], s1_own_ff} - {s1_other_ff[ELEM_W-1], s1_other_ff};
      diff_abs = diff[ELEM_W] ? (ELEM_W+1)'(0) - diff : diff;
      mag      = diff_abs[MAG_W-1:0];
      sq       = mag * mag;
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (adv1) begin
         s2_valid_in = 1'b1;
      end else if (adv2) begin
         s2_valid_in = 1'b0;
      end
   end

   always_comb begin
      base     = s2_pos_ff.first ? '0 : sum_ff;
      halt_eff = s2_pos_ff.first ? 1'b0 : halted_ff;
      mode_eff = s2_pos_ff.first ? s2_enable_ff : mode_ff;
      bnd      = s2_pos_ff.first ? s2_bound_ff : bound_ff;
      acc      = base + DIST_W'(s2_sq_ff);
      stop     = mode_eff && s2_pos_ff.check && (acc > bnd);
      produce  = !halt_eff && (stop || s2_pos_ff.last);

      sum_in    = sum_ff;
      halted_in = halted_ff;
      bound_in  = bound_ff;
      mode_in   = mode_ff;
      if (adv2) begin
         bound_in  = bnd;
         mode_in   = mode_eff;
         sum_in    = halt_eff ? base : acc;
         halted_in = halt_eff || stop;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_stop_in  = rsp_stop_ff;
      if (adv2 && produce) begin
         rsp_valid_in = 1'b1;
         rsp_dist_in  = acc;
         rsp_stop_in  = stop;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         halted_ff    <= 1'b0;
         bound_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         sum_ff       <= sum_in;
         halted_ff    <= halted_in;
         bound_ff     <= bound_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_own_ff    <= req_chan.elem_own;
         s1_other_ff  <= req_chan.elem_other;
         s1_pos_ff    <= pos;
         s1_enable_ff <= req_chan.bound_enable;
         s1_bound_ff  <= req_chan.bound_limit;
      end
      if (adv1) begin
         s2_sq_ff     <= sq;
         s2_pos_ff    <= s1_pos_ff;
         s2_enable_ff <= s1_enable_ff;
         s2_bound_ff  <= s1_bound_ff;
      end
      rsp_dist_ff <= rsp_dist_in;
      rsp_stop_ff <= rsp_stop_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.distance      = rsp_dist_ff;
   assign rsp_chan.stopped_early = rsp_stop_ff;

endmodule

`default_nettype wire

// File: rtl/bsd_checker.sv
// bsd_checker: port-level assertions for bounded_squared_distance
// depends on bsd_pkg; bound to the top level at the end of this file
`default_nettype none

module bsd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bsd_pkg::dist_type rsp_distance,
   input logic              rsp_stopped_early
);
   import bsd_pkg::*;

   // no result item straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item right after reset");

   // a stop means the sum exceeded a bound, so it cannot be zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopped_early |-> rsp_distance != '0)
      else $error("stopped item with zero distance");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_distance) && $stable(rsp_stopped_early))
      else $error("result item changed while stalled");

endmodule

bind bounded_squared_distance bsd_checker u_bsd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_distance      (rsp_chan.distance),
   .rsp_stopped_early (rsp_chan.stopped_early)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for bounded_squared_distance, one dimension item per handshake
// depends on bsd_pkg, bsd_req_if, bsd_rsp_if and the rtl top level; directed table then random vectors

module tb;
   import bsd_pkg::*;

   localparam int DIMS          = DIMS_DEFAULT;
   localparam int FIRST_CHECK   = (2 * DIMS) / 5;
   localparam int HALF_PERIOD   = 5;
   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 900;
   localparam int TAIL_ITEMS    = 120;
   localparam int LONG_HOLD_AT  = 300;
   localparam int LONG_HOLD     = 60;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   localparam elem_type E_MAX     = 16'sh7FFF;
   localparam elem_type E_MIN     = 16'sh8000;
   localparam elem_type E_ZERO    = 16'sh0000;
   localparam elem_type E_ONE     = 16'sh0001;
   localparam elem_type E_NEG_ONE = 16'shFFFF;
   localparam dist_type BOUND_A   = 48'd38653526024;
   localparam dist_type STOP_A    = 48'd38653526025;
   localparam dist_type BOUND_MAX = 48'hFFFF_FFFF_FFFF;
   localparam dist_type NO_DIST   = 48'd0;

   typedef struct packed {
      elem_type own;
      elem_type other;
      logic     bound_en;
      dist_type bound;
   } dim_item_type;

   typedef struct packed {
      dist_type distance;
      logic     stopped;
   } dist_result_type;

   typedef struct packed {
      elem_type own;
      elem_type other;
      logic     bound_en;
      dist_type bound;
      logic     typed;
      dist_type want_dist;
      logic     want_stop;
   } dim_row_type;

   // vector a: bound one below nine full-scale squares, stops at the first checked index
   // vector b: bound at its maximum, first half only; the random part carries it on
   dim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{E_MAX,     E_MIN,  1'b1, BOUND_A,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_MAX,  1'b0, BOUND_MAX, 1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_MIN,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_MAX,  1'b1, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_MIN,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_MAX,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_MIN,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_MAX,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_MIN,  1'b0, NO_DIST,   1'b1, STOP_A,  1'b1},
      '{E_MAX,     E_MIN,  1'b1, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_MAX,  1'b0, BOUND_MAX, 1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_MIN,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_MAX,  1'b1, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_MIN,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_MAX,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_MIN,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_MIN,  1'b1, BOUND_MAX, 1'b0, NO_DIST, 1'b0},
      '{E_ZERO,    E_ZERO, 1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_MAX,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_ONE,     E_NEG_ONE, 1'b0, NO_DIST, 1'b0, NO_DIST, 1'b0},
      '{E_NEG_ONE, E_ZERO, 1'b1, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MAX,     E_ZERO, 1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_ZERO,    E_MIN,  1'b0, NO_DIST,   1'b0, NO_DIST, 1'b0},
      '{E_MIN,     E_ZERO, 1'b0, BOUND_MAX, 1'b0, NO_DIST, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   bsd_req_if req_chan ();
   bsd_rsp_if rsp_chan ();

   bounded_squared_distance #(.DIMS(DIMS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state, mirrors the block after reset
   dist_type   acc_sum    = '0;
   logic [7:0] dim_pos    = '0;
   logic       vec_halted = 1'b0;
   dist_type   bound_val  = '0;
   logic       bound_on   = 1'b0;

   dist_result_type distance_expected [$];

   int items_taken   = 0;
   int results_seen  = 0;
   int early_stops   = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   bit tail_phase    = 1'b0;
   bit stim_done     = 1'b0;

   function automatic bit predict_distance(input dim_item_type it, output dist_result_type res);
      longint diff;
      bit     last;
      bit     hit;
      last = (dim_pos == DIMS - 1);
      hit  = 1'b0;
      res  = '0;
      if (dim_pos == 0) begin
         acc_sum    = '0;
         vec_halted = 1'b0;
         bound_on   = it.bound_en;
         bound_val  = it.bound;
      end
      if (!vec_halted) begin
         diff    = longint'(it.own) - longint'(it.other);
         acc_sum = acc_sum + dist_type'(diff * diff);
         if (bound_on && dim_pos >= FIRST_CHECK && dim_pos[1:0] == 2'b00 &&
             acc_sum > bound_val) begin
            vec_halted = 1'b1;
            res        = '{acc_sum, 1'b1};
            hit        = 1'b1;
         end else if (last) begin
            res = '{acc_sum, 1'b0};
            hit = 1'b1;
         end
      end
      dim_pos = last ? 8'd0 : dim_pos + 8'd1;
      return hit;
   endfunction

   function automatic elem_type random_elem(input int lim);
      return elem_type'($urandom_range(0, 2 * lim + 1) - lim - 1);
   endfunction

   function automatic dist_type random_wide();
      return dist_type'({$urandom(), $urandom()});
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("mismatch: %s", msg);
   endtask

   task automatic send_dim(input dim_item_type it);
      req_chan.valid        <= 1'b1;
      req_chan.elem_own     <= it.own;
      req_chan.elem_other   <= it.other;
      req_chan.bound_enable <= it.bound_en;
      req_chan.bound_limit  <= it.bound;
      @(posedge clock);
      while (req_chan.ready !== 1'b1)
         @(posedge clock);
      items_taken++;
   endtask

   task automatic idle_gap();
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   initial begin : req_driver
      dim_item_type    it;
      dist_result_type want;
      bit              have;
      bit              gappy;
      int              lim;
      int              mode;
      int              pos;
      bit              vec_bound_en;
      dist_type        vec_bound;
      req_chan.valid        <= 1'b0;
      req_chan.elem_own     <= '0;
      req_chan.elem_other   <= '0;
      req_chan.bound_enable <= 1'b0;
      req_chan.bound_limit  <= '0;
      gappy        = 1'b1;
      lim          = 32767;
      mode         = 2;
      vec_bound_en = 1'b0;
      vec_bound    = '0;
      do @(posedge clock); while (reset !== 1'b0);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         it = '{directed_rows[i].own, directed_rows[i].other,
                directed_rows[i].bound_en, directed_rows[i].bound};
         send_dim(it);
         have = predict_distance(it, want);
         if (directed_rows[i].typed) begin
            want = '{directed_rows[i].want_dist, directed_rows[i].want_stop};
            have = 1'b1;
         end
         if (have)
            distance_expected.push_back(want);
         if ($urandom_range(0, 3) == 0)
            idle_gap();
      end

      while (items_taken < DIRECTED_ROWS + RANDOM_ITEMS) begin
         pos = items_taken % DIMS;
         if (pos == 0) begin
            gappy = ($urandom_range(0, 2) != 0);
            mode  = $urandom_range(0, 9);
            case ($urandom_range(0, 3))
               0: lim = 1;
               1: lim = 255;
               2: lim = 4095;
               default: lim = 32767;
            endcase
            vec_bound_en = ($urandom_range(0, 9) < 7);
            case ($urandom_range(0, 9))
               0: vec_bound = '0;
               1: vec_bound = BOUND_MAX;
               2, 3: vec_bound = random_wide();
               default: vec_bound = dist_type'(longint'(lim + 1) * longint'(lim + 1) *
                                               longint'($urandom_range(2, 14)));
            endcase
         end
         if (mode == 0) begin
            if ($urandom_range(0, 1)) begin
               it.own   = E_MAX;
               it.other = E_MIN;
            end else begin
               it.own   = E_MIN;
               it.other = E_MAX;
            end
         end else begin
            it.own   = random_elem(lim);
            it.other = (mode == 1) ? it.own : random_elem(lim);
         end
         // fields after the first dimension are noise the block must not latch
         it.bound_en = $urandom_range(0, 1);
         it.bound    = random_wide();
         if (pos == 0) begin
            it.bound_en = vec_bound_en;
            it.bound    = vec_bound;
         end
         tail_phase = (items_taken >= DIRECTED_ROWS + RANDOM_ITEMS - TAIL_ITEMS);
         send_dim(it);
         if (predict_distance(it, want))
            distance_expected.push_back(want);
         if (gappy && !tail_phase && $urandom_range(0, 3) == 0)
            idle_gap();
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin : rsp_driver
      int stall_left;
      bit stalls_on;
      bit held;
      rsp_chan.ready <= 1'b0;
      stall_left = 0;
      stalls_on  = 1'b1;
      held       = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (!held && items_taken >= LONG_HOLD_AT) begin
            // long hold so the pipe fills and the input stalls
            held       = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !tail_phase) begin
            if ($urandom_range(0, 63) == 0)
               stalls_on = !stalls_on;
            if (stalls_on && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      dist_result_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         results_seen++;
         if (rsp_chan.stopped_early === 1'b1)
            early_stops++;
         if (distance_expected.size() == 0) begin
            flag_error($sformatf("unexpected result distance %0d stop %0b",
                                 rsp_chan.distance, rsp_chan.stopped_early));
         end else begin
            want = distance_expected.pop_front();
            if (rsp_chan.distance !== want.distance || rsp_chan.stopped_early !== want.stopped)
               flag_error($sformatf("result %0d: expected distance %0d stop %0b, got %0d stop %0b",
                                    results_seen, want.distance, want.stopped,
                                    rsp_chan.distance, rsp_chan.stopped_early));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, distance_expected.size());
         $display("tb: errors");
         $finish;
      end
   end

   initial begin : run_control
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (distance_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d items over %0d vectors, %0d results checked, %0d stopped on the bound",
               items_taken, items_taken / DIMS, results_seen, early_stops);
      $display("summary: %0d mismatches, long output hold applied once", error_count);
      if (error_count == 0 && distance_expected.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// File: bounded_squared_distance.f
rtl/bsd_pkg.sv
rtl/bsd_req_if.sv
rtl/bsd_rsp_if.sv
rtl/bounded_squared_distance.sv
rtl/bsd_checker.sv
verif/tb.sv
